/* rtl/core/upu_pkg.sv */
// Shared constants and types of the percent-unescaper.
package upu_pkg;

  localparam logic [7:0] CH_PERCENT  = 8'h25;
  localparam logic [7:0] CH_PLUS     = 8'h2b;
  localparam logic [7:0] CH_QUERY    = 8'h3f;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CASE_BIT    = 8'h20;
  localparam logic [7:0] REDIR_UPPER = 8'h7f;

  localparam int unsigned MODE_URI_BIT   = 0;
  localparam int unsigned MODE_REDIR_BIT = 1;

  localparam logic [1:0] PH_NORMAL  = 2'd0;
  localparam logic [1:0] PH_PERCENT = 2'd1;
  localparam logic [1:0] PH_DIGIT   = 2'd2;
  localparam logic [1:0] PH_STOPPED = 2'd3;

  localparam int unsigned MAX_DATA = 3;

  typedef struct packed {
    logic [MAX_DATA-1:0][7:0] data;
    logic [1:0]               ndata;
    logic                     mark;
  } burst_t;

endpackage

/* rtl/core/upu_stream_if.sv */
// Handshake interfaces for the encoded input beats and the decoded result beats.
interface upu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface upu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       string_end;
  logic       run_last;

  modport source (output valid, output out_byte, output has_byte, output string_end,
                  output run_last, input ready);
  modport sink (input valid, input out_byte, input has_byte, input string_end,
                input run_last, output ready);
endinterface

/* rtl/core/upu_decoder.sv */
// Escape decoder: holds the decode state and turns one input byte into a result burst.
module upu_decoder
  import upu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] ch,
  input  logic       last,
  input  logic [1:0] mode,
  output burst_t     burst
);

  logic [1:0] phase_r, phase_nxt;
  logic [3:0] hi_r, hi_nxt;
  logic [7:0] fdc_r, fdc_nxt;

  logic [7:0] lc;
  logic       is_num, is_let, uri, redir, in_range;
  logic [3:0] lo;
  logic [7:0] v;

  assign lc       = ch | CASE_BIT;
  assign is_num   = ch inside {[8'h30:8'h39]};
  assign is_let   = lc inside {[8'h61:8'h66]};
  assign uri      = mode[MODE_URI_BIT];
  assign redir    = mode[MODE_REDIR_BIT];
  assign lo       = is_num ? ch[3:0] : (lc[3:0] + 4'd9);
  assign v        = {hi_r, lo};
  assign in_range = (v > CH_PERCENT) && (v < REDIR_UPPER);

  always_comb begin
    phase_nxt   = phase_r;
    hi_nxt      = hi_r;
    fdc_nxt     = fdc_r;
    burst.data  = '0;
    burst.ndata = 2'd0;
    burst.mark  = last;
    case (phase_r)
      PH_NORMAL: begin
        if (ch == CH_QUERY && (uri || redir)) begin
          burst.data[0] = ch;
          burst.ndata   = 2'd1;
          phase_nxt     = PH_STOPPED;
        end else if (ch == CH_PERCENT) begin
          phase_nxt = PH_PERCENT;
        end else if (ch == CH_PLUS) begin
          burst.data[0] = CH_SPACE;
          burst.ndata   = 2'd1;
        end else begin
          burst.data[0] = ch;
          burst.ndata   = 2'd1;
        end
      end
      PH_PERCENT: begin
        if (is_num || is_let) begin
          hi_nxt    = lo;
          fdc_nxt   = ch;
          phase_nxt = PH_DIGIT;
        end else begin
          burst.data[0] = ch;
          burst.ndata   = 2'd1;
          phase_nxt     = PH_NORMAL;
        end
      end
      PH_DIGIT: begin
        phase_nxt     = PH_NORMAL;
        burst.data[0] = v;
        if (is_num) begin
          burst.ndata = 2'd1;
          if (redir && !in_range) begin
            burst.data[0] = CH_PERCENT;
            burst.data[1] = fdc_r;
            burst.data[2] = ch;
            burst.ndata   = 2'd3;
          end
        end else if (is_let) begin
          burst.ndata = 2'd1;
          if (uri) begin
            if (v == CH_QUERY) begin
              phase_nxt = PH_STOPPED;
            end
          end else if (redir) begin
            if (v == CH_QUERY) begin
              phase_nxt = PH_STOPPED;
            end else if (!in_range) begin
              burst.data[0] = CH_PERCENT;
              burst.data[1] = fdc_r;
              burst.data[2] = ch;
              burst.ndata   = 2'd3;
            end
          end
        end
      end
      default: begin
      end
    endcase
    if (last) begin
      phase_nxt = PH_NORMAL;
      hi_nxt    = 4'd0;
      fdc_nxt   = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_NORMAL;
      hi_r    <= 4'd0;
      fdc_r   <= 8'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      hi_r    <= hi_nxt;
      fdc_r   <= fdc_nxt;
    end
  end

endmodule

/* rtl/core/upu_emitter.sv */
// Result register: holds one burst and hands its results out one beat at a time.
module upu_emitter
  import upu_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   load,
  input  burst_t burst,
  output logic   can_take,
  upu_out_if.source out_ch
);

  logic                     busy_r;
  logic [MAX_DATA-1:0][7:0] data_r;
  logic [1:0]               ndata_r;
  logic                     mark_r;
  logic [1:0]               idx_r;
  logic [2:0]               total;
  logic                     at_last, fire, is_data;

  assign total    = {1'b0, ndata_r} + {2'b00, mark_r};
  assign at_last  = ({1'b0, idx_r} == (total - 3'd1));
  assign fire     = busy_r && out_ch.ready;
  assign can_take = !busy_r || (out_ch.ready && at_last);
  assign is_data  = idx_r < ndata_r;

  assign out_ch.valid      = busy_r;
  assign out_ch.has_byte   = is_data;
  assign out_ch.string_end = !is_data;
  assign out_ch.run_last   = at_last;

  always_comb begin
    case (idx_r)
      2'd0:    out_ch.out_byte = data_r[0];
      2'd1:    out_ch.out_byte = data_r[1];
      2'd2:    out_ch.out_byte = data_r[2];
      default: out_ch.out_byte = 8'd0;
    endcase
    if (!is_data) begin
      out_ch.out_byte = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else if (load) begin
      busy_r <= 1'b1;
      idx_r  <= 2'd0;
    end else if (fire && at_last) begin
      busy_r <= 1'b0;
    end else if (fire) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r  <= burst.data;
      ndata_r <= burst.ndata;
      mark_r  <= burst.mark;
    end
  end

endmodule

/* rtl/core/uri_percent_unescaper.sv */
// Top level of the percent-unescaper: mode register, decoder and result register.
// The first result of a byte appears in the cycle after the byte's beat is accepted.
// Throughput: one byte per cycle while out_ch is ready and each byte gives at most
// one output beat; a byte giving more beats holds the input until its last beat is taken.
// Reset (synchronous, rst_n low) clears mode, decode state and result-register busy flag.
module uri_percent_unescaper
  import upu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata,
  upu_in_if.sink     in_ch,
  upu_out_if.source  out_ch
);

  logic [1:0] mode_r;
  logic       accept, can_take;
  burst_t     burst;

  assign in_ch.ready = can_take;
  assign accept      = in_ch.valid && can_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 2'd0;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  upu_decoder u_decoder (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .ch     (in_ch.in_byte),
    .last   (in_ch.in_last),
    .mode   (mode_r),
    .burst  (burst)
  );

  upu_emitter u_emitter (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (accept && ((burst.ndata != 2'd0) || burst.mark)),
    .burst    (burst),
    .can_take (can_take),
    .out_ch   (out_ch)
  );

endmodule
